>>> rtl/tsrr_pkg.sv
// Shared types and constants for the task sleep timer / round-robin switcher.
// Holds the action codes, field widths and the per-task command struct.
// No dependencies.
package tsrr_pkg;

  localparam int unsigned TaskCountDef = 8;

  localparam int unsigned ActionW = 2;
  localparam int unsigned ReqW    = 3;
  localparam int unsigned DelayW  = 16;
  localparam int unsigned PtrW    = 8;
  localparam int unsigned CurW    = 3;
  localparam int unsigned MaskW   = 8;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [ActionW-1:0] {
    ACT_TICK   = 2'd0,
    ACT_SLEEP  = 2'd1,
    ACT_SWITCH = 2'd2,
    ACT_LOAD   = 2'd3
  } action_e;

  // Command to one task lane for one transaction; tick and delay go to every lane.
  typedef struct packed {
    logic              tick;
    logic              sleep;
    logic [DelayW-1:0] delay;
  } lane_cmd_t;

endpackage

>>> rtl/tsrr_task_lane.sv
// Per-task sleep state: suspended flag, elapsed tick count and sleep length.
// Depends on tsrr_pkg for the lane command struct.
module tsrr_task_lane import tsrr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lane_cmd_t cmd_i,     // one-cycle command, already qualified
  output logic      awake_d_o  // running flag after this command
);

  logic              sleeping_q, sleeping_d;
  logic [DelayW-1:0] elapsed_q, elapsed_d;
  logic [DelayW-1:0] length_q, length_d;
  logic [DelayW-1:0] elapsed_inc;

  // Saturate the count at the top of its range.
  assign elapsed_inc = (sleeping_q && (elapsed_q != '1)) ? elapsed_q + DelayW'(1) : elapsed_q;

  always_comb begin
    sleeping_d = sleeping_q;
    elapsed_d  = elapsed_q;
    length_d   = length_q;
    if (cmd_i.sleep) begin
      sleeping_d = 1'b1;
      elapsed_d  = '0;
      length_d   = cmd_i.delay;
    end else if (cmd_i.tick) begin
      if (elapsed_inc >= length_q) begin
        sleeping_d = 1'b0;
        elapsed_d  = '0;
      end else begin
        elapsed_d  = elapsed_inc;
      end
    end
  end

  assign awake_d_o = ~sleeping_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sleeping_q <= 1'b0;
      elapsed_q  <= '0;
      length_q   <= '0;
    end else begin
      sleeping_q <= sleeping_d;
      elapsed_q  <= elapsed_d;
      length_q   <= length_d;
    end
  end

endmodule

>>> rtl/task_sleep_timer_round_robin.sv
// Path: an accepted transaction is held in the input register, then written to the result register.
// Throughput: one transaction per cycle while the output is not stalled; every task lane updates in parallel
// between the input register and the result register.
// Reset: all tasks running with zero count and length, task 0 current,
// both stages empty. Saved stack pointers are undefined until loaded.
// Depends on tsrr_pkg and tsrr_task_lane.
module task_sleep_timer_round_robin import tsrr_pkg::*; #(
  parameter int unsigned TASK_COUNT = TaskCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // task_req[2:0], delay[18:3], stack_ptr[26:19]
  input  logic [ActionW-1:0]  s_axis_tuser,  // action[1:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata   // current_task[2:0], next_stack_ptr[10:3],
                                             // awake_mask[18:11]
);

  localparam int unsigned TaskW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam logic [TaskW-1:0] LastTask = TaskW'(TASK_COUNT - 1);

  // Input register
  logic              in_valid_q;
  action_e           in_action_q;
  logic [ReqW-1:0]   in_req_q;
  logic [DelayW-1:0] in_delay_q;
  logic [PtrW-1:0]   in_sp_q;

  // Result register
  logic              out_valid_q;
  logic [CurW-1:0]   out_cur_q;
  logic [PtrW-1:0]   out_sp_q;
  logic [MaskW-1:0]  out_mask_q;

  // Task state
  logic [TaskW-1:0]  active_q, active_d, active_inc;
  logic [PtrW-1:0]   saved_ptr [TASK_COUNT];

  logic              advance;
  logic              req_ok;
  logic [TaskW-1:0]  req_idx;
  logic [TASK_COUNT-1:0] awake_d;
  logic [MaskW-1:0]  mask_d;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  assign req_ok  = 32'(in_req_q) < TASK_COUNT;
  assign req_idx = TaskW'(in_req_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_action_q <= action_e'(s_axis_tuser);
      in_req_q    <= s_axis_tdata[2:0];
      in_delay_q  <= s_axis_tdata[18:3];
      in_sp_q     <= s_axis_tdata[26:19];
    end
  end

  // Per-task lanes
  for (genvar t = 0; t < TASK_COUNT; t++) begin : g_lane
    lane_cmd_t cmd;
    assign cmd.tick  = advance && (in_action_q == ACT_TICK);
    assign cmd.sleep = advance && (in_action_q == ACT_SLEEP) && req_ok
                       && (32'(in_req_q) == t);
    assign cmd.delay = in_delay_q;

    tsrr_task_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .awake_d_o (awake_d[t])
    );
  end

  always_comb begin
    mask_d = '0;
    for (int unsigned t = 0; t < MaskW; t++) begin
      if (t < TASK_COUNT) begin
        mask_d[t] = awake_d[t];
      end
    end
  end

  // Round-robin advance
  assign active_inc = (active_q == LastTask) ? '0 : active_q + TaskW'(1);

  always_comb begin
    active_d = active_q;
    if (advance && (in_action_q == ACT_SWITCH)) begin
      active_d = active_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else begin
      active_q <= active_d;
    end
  end

  // Saved stack pointers: switch writes the outgoing task, reads the incoming; load writes the named one.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      unique case (in_action_q)
        ACT_SWITCH: begin
          saved_ptr[active_q] <= in_sp_q;
          out_sp_q            <= saved_ptr[active_inc];
        end
        ACT_LOAD: begin
          if (req_ok) begin
            saved_ptr[req_idx] <= in_sp_q;
          end
          out_sp_q <= '0;
        end
        ACT_TICK, ACT_SLEEP: begin
          out_sp_q <= '0;
        end
        default: begin
          out_sp_q <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_cur_q  <= CurW'(active_d);
      out_mask_q <= mask_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_mask_q, out_sp_q, out_cur_q};

  // Assertions
  a_active_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(active_q) < TASK_COUNT)
    else $error("active task out of range");

  a_hold_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && (in_action_q == ACT_SWITCH)) |=> $stable(active_q))
    else $error("active task moved without a switch");

  a_sp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (in_action_q != ACT_SWITCH)) |=> (m_axis_tdata[10:3] == '0))
    else $error("stack pointer reported on a non-switch result");

  a_cur_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (m_axis_tdata[2:0] == CurW'(active_q)))
    else $error("reported task differs from active task");

endmodule

>>> test/task_sleep_timer_round_robin_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for task_sleep_timer_round_robin: tick, sleep, switch and load
// transactions are predicted by a local kernel model and compared with each result.
// Depends on tsrr_pkg and the RTL top only.
module task_sleep_timer_round_robin_tb;
  import tsrr_pkg::*;

  localparam int unsigned NTASK        = TaskCountDef;
  localparam int unsigned RANDOM_ITEMS = 1900;
  localparam int unsigned LIMIT_CYCLES = 200_000;
  localparam int unsigned TAIL_CYCLES  = 6;

  typedef struct packed {
    action_e           act;
    logic [ReqW-1:0]   req;
    logic [DelayW-1:0] dly;
    logic [PtrW-1:0]   sp;
  } kernel_cmd_t;

  typedef struct packed {
    logic [CurW-1:0]  cur_task;
    logic [PtrW-1:0]  next_sp;
    logic [MaskW-1:0] awake;
  } kernel_status_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [ActionW-1:0]  s_axis_tuser  = ACT_TICK;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  task_sleep_timer_round_robin dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  kernel_cmd_t    kernel_cmd_q[$];
  kernel_status_t expected_status_q[$];

  int unsigned total_items  = 0;
  int unsigned accepted_cnt = 0;
  int unsigned fail_cnt     = 0;
  int unsigned cycle_cnt    = 0;
  logic        in_taken     = 1'b0;

  // Predicted kernel state
  logic [ReqW-1:0]   active_q;
  logic [PtrW-1:0]   sp_store  [NTASK];
  logic              asleep    [NTASK];
  logic [DelayW-1:0] tick_count[NTASK];
  logic [DelayW-1:0] sleep_len [NTASK];

  // Stimulus-side tracking so that no switch lands on an unwritten pointer
  logic [ReqW-1:0] gen_cur = '0;
  logic            gen_written[NTASK];

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [ReqW-1:0] next_task(logic [ReqW-1:0] t);
    return (t + 1 >= NTASK) ? '0 : t + 1'b1;
  endfunction

  function automatic kernel_status_t kernel_step(kernel_cmd_t c);
    kernel_status_t st;
    st = '0;
    case (c.act)
      ACT_TICK: begin
        for (int t = 0; t < NTASK; t++) begin
          if (asleep[t] && tick_count[t] != '1) tick_count[t] = tick_count[t] + 1'b1;
          if (tick_count[t] >= sleep_len[t]) begin
            asleep[t]     = 1'b0;
            tick_count[t] = '0;
          end
        end
      end
      ACT_SLEEP: begin
        if (c.req < NTASK) begin
          asleep[c.req]     = 1'b1;
          tick_count[c.req] = '0;
          sleep_len[c.req]  = c.dly;
        end
      end
      ACT_SWITCH: begin
        sp_store[active_q] = c.sp;
        active_q           = next_task(active_q);
        st.next_sp         = sp_store[active_q];
      end
      default: begin
        if (c.req < NTASK) sp_store[c.req] = c.sp;
      end
    endcase
    st.cur_task = active_q;
    for (int t = 0; t < NTASK && t < MaskW; t++) st.awake[t] = !asleep[t];
    return st;
  endfunction

  task automatic queue_cmd(action_e act, int unsigned req, int unsigned dly, int unsigned sp);
    kernel_cmd_t c;
    c.act = act;
    c.req = req[ReqW-1:0];
    c.dly = dly[DelayW-1:0];
    c.sp  = sp[PtrW-1:0];
    if (act == ACT_SWITCH) begin
      gen_written[gen_cur] = 1'b1;
      gen_cur = next_task(gen_cur);
    end else if (act == ACT_LOAD) begin
      gen_written[c.req] = 1'b1;
    end
    kernel_cmd_q.push_back(c);
  endtask

  // Sender idles 11% / receiver 50%, then swapped, then no idling at all.
  function automatic int unsigned idle_pct(bit sender);
    int unsigned phase;
    phase = (total_items == 0) ? 0 : (accepted_cnt * 3) / total_items;
    case (phase)
      0:       return sender ? 11 : 50;
      1:       return sender ? 50 : 11;
      default: return 0;
    endcase
  endfunction

  always @(negedge clk_i) begin : drive_proc
    kernel_cmd_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !in_taken) begin
      // hold the offered transaction until it is taken
    end else if (kernel_cmd_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
      nxt = kernel_cmd_q.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {5'b0, nxt.sp, nxt.dly, nxt.req};
      s_axis_tuser  <= nxt.act;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= idle_pct(1'b0));
  end

  // Check results first, then predict the transaction accepted at this edge.
  always @(posedge clk_i) begin : check_proc
    kernel_cmd_t    acc;
    kernel_status_t want;
    kernel_status_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.cur_task = m_axis_tdata[2:0];
      got.next_sp  = m_axis_tdata[10:3];
      got.awake    = m_axis_tdata[18:11];
      if (expected_status_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result: task %0d sp %02h awake %02h",
                   got.cur_task, got.next_sp, got.awake);
      end else begin
        want = expected_status_q.pop_front();
        if (got !== want) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch: task %0d/%0d sp %02h/%02h awake %02h/%02h (exp/act)",
                     want.cur_task, got.cur_task, want.next_sp, got.next_sp,
                     want.awake, got.awake);
        end
      end
    end
    in_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      acc.act = action_e'(s_axis_tuser);
      acc.req = s_axis_tdata[2:0];
      acc.dly = s_axis_tdata[18:3];
      acc.sp  = s_axis_tdata[26:19];
      expected_status_q.push_back(kernel_step(acc));
      accepted_cnt++;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("task_sleep_timer_round_robin_tb: errors");
      $finish;
    end
  end

  initial begin : main_proc
    int unsigned pick;
    int unsigned dly;
    active_q = '0;
    for (int t = 0; t < NTASK; t++) begin
      sp_store[t]    = '0;
      asleep[t]      = 1'b0;
      tick_count[t]  = '0;
      sleep_len[t]   = '0;
      gen_written[t] = 1'b0;
    end

    // Directed: wake on zero length, max length, staggered wakes, wrap of the task number.
    queue_cmd(ACT_TICK, 0, 16'hFFFF, 8'hFF);
    queue_cmd(ACT_SLEEP, 0, 0, 0);
    queue_cmd(ACT_TICK, 0, 0, 0);
    queue_cmd(ACT_SLEEP, 7, 16'hFFFF, 8'hFF);
    queue_cmd(ACT_SLEEP, 1, 1, 0);
    queue_cmd(ACT_SLEEP, 2, 2, 0);
    queue_cmd(ACT_TICK, 0, 0, 0);
    queue_cmd(ACT_TICK, 0, 0, 0);
    queue_cmd(ACT_TICK, 0, 0, 0);
    queue_cmd(ACT_LOAD, 1, 0, 8'hFF);
    queue_cmd(ACT_LOAD, 2, 0, 8'h00);
    queue_cmd(ACT_SWITCH, 0, 0, 8'hAA);
    queue_cmd(ACT_SWITCH, 0, 0, 8'h55);
    for (int t = 3; t < NTASK; t++) queue_cmd(ACT_LOAD, t, 0, 8'h10 + t);
    for (int t = 2; t < NTASK; t++) queue_cmd(ACT_SWITCH, 0, 0, 8'h80 + t);

    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        queue_cmd(ACT_TICK, $urandom_range(7), $urandom_range(65535), $urandom_range(255));
      end else if (pick < 65) begin
        pick = $urandom_range(99);
        if (pick < 60)      dly = $urandom_range(6);
        else if (pick < 85) dly = $urandom_range(40, 7);
        else                dly = $urandom_range(65535);
        queue_cmd(ACT_SLEEP, $urandom_range(7), dly, $urandom_range(255));
      end else if (pick < 85) begin
        // a switch onto a never-written pointer becomes a load of that task
        if (gen_written[next_task(gen_cur)])
          queue_cmd(ACT_SWITCH, $urandom_range(7), $urandom_range(65535), $urandom_range(255));
        else
          queue_cmd(ACT_LOAD, next_task(gen_cur), $urandom_range(65535), $urandom_range(255));
      end else begin
        queue_cmd(ACT_LOAD, $urandom_range(7), $urandom_range(65535), $urandom_range(255));
      end
    end
    total_items = kernel_cmd_q.size();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (!(accepted_cnt == total_items && expected_status_q.size() == 0))
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (fail_cnt == 0 && expected_status_q.size() == 0) begin
      $display("task_sleep_timer_round_robin_tb: clean");
    end else begin
      $display("task_sleep_timer_round_robin_tb: errors");
    end
    $finish;
  end

endmodule

>>> task_sleep_timer_round_robin.f
rtl/tsrr_pkg.sv
rtl/tsrr_task_lane.sv
rtl/task_sleep_timer_round_robin.sv
test/task_sleep_timer_round_robin_tb.sv
